// ----- design/bms_pkg.sv -----
// Package for the block merge sorter: sizes, the cell link record and cell controls.
// No dependencies; every other design file imports it.
`default_nettype none

package bms_pkg;

    localparam int BLOCK_LEN = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

    typedef logic signed [VAL_W-1:0] val_t;

    // what one cell shows to its neighbors
    typedef struct packed {
        val_t value;
        logic valid;
        logic keep;     // cell holds a value <= the value being inserted
    } cell_link_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/bms_in_if.sv -----
// Input channel of the block merge sorter: valid/ready with value and last.
// Depends on bms_pkg.
`default_nettype none

interface bms_in_if
    import bms_pkg::*;
;
    logic valid;
    logic ready;
    val_t value;
    logic last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

// ----- design/bms_out_if.sv -----
// Result channel of the block merge sorter: valid/ready with value_res and last_res.
// Depends on bms_pkg.
`default_nettype none

interface bms_out_if
    import bms_pkg::*;
;
    logic valid;
    logic ready;
    val_t value_res;
    logic last_res;

    modport source (output valid, output value_res, output last_res, input ready);
    modport sink   (input valid, input value_res, input last_res, output ready);
endinterface

`default_nettype wire

// ----- design/bms_cell.sv -----
// One sorter cell: holds one value, inserts in order and shifts left on drain.
// Depends on bms_pkg.
`default_nettype none

module bms_cell
    import bms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire val_t       new_value,
    input  wire cell_link_t left,
    input  wire cell_link_t right,
    output cell_link_t      link
);

    val_t value_reg, value_next;
    logic valid_reg, valid_next;
    logic keep;

    assign keep = valid_reg && (value_reg <= new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert)
        begin
            if (!keep)
            begin
                // left keeps its value: the new one lands here, else take left's
                value_next = left.keep ? new_value : left.value;
                valid_next = left.keep ? 1'b1 : left.valid;
            end
        end
        else if (ctrl.shift)
        begin
            value_next = right.value;
            valid_next = right.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.valid = valid_reg;
    assign link.keep  = keep;

endmodule

`default_nettype wire

// ----- design/block_merge_sorter_core.sv -----
// Top level of the block merge sorter: a row of sorting cells and the fill/drain control.
// Depends on bms_pkg, bms_in_if, bms_out_if and bms_cell.
//
//   channel   direction  payload              transfer when
//   item      in         value[31:0], last    item.valid && item.ready
//   result    out        value_res, last_res  result.valid && result.ready
//
// Each accepted item is inserted in sorted position as it is taken; draining gives
// one result per cycle while result.ready is high, n in all for a block of n.
// Input is held off while a block drains. Reset empties every cell at once.
// A stalled result holds in cell 0 until taken.
`default_nettype none

module block_merge_sorter_core
    import bms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bms_in_if.sink     item,
    bms_out_if.source  result
);

    logic             drain_reg, drain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             in_xfer, out_xfer;
    cell_ctrl_t       ctrl;
    cell_link_t       links    [BLOCK_LEN];
    cell_link_t       left_in  [BLOCK_LEN];
    cell_link_t       right_in [BLOCK_LEN];

    assign item.ready = !drain_reg;
    assign in_xfer    = item.valid && item.ready;
    assign out_xfer   = result.valid && result.ready;

    assign ctrl.insert = in_xfer;
    assign ctrl.shift  = out_xfer;

    genvar i;
    generate
        for (i = 0; i < BLOCK_LEN; i++)
        begin : g_cell
            if (i == 0)
            begin : g_left_edge
                always_comb
                begin
                    left_in[i].value = '0;
                    left_in[i].valid = 1'b1;
                    left_in[i].keep  = 1'b1;
                end
            end
            else
            begin : g_left
                assign left_in[i] = links[i-1];
            end

            if (i == BLOCK_LEN - 1)
            begin : g_right_edge
                always_comb
                begin
                    right_in[i].value = '0;
                    right_in[i].valid = 1'b0;
                    right_in[i].keep  = 1'b0;
                end
            end
            else
            begin : g_right
                assign right_in[i] = links[i+1];
            end

            bms_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .new_value (item.value),
                .left      (left_in[i]),
                .right     (right_in[i]),
                .link      (links[i])
            );
        end
    endgenerate

    assign result.valid     = drain_reg;
    assign result.value_res = links[0].value;
    assign result.last_res  = !links[1].valid;

    always_comb
    begin
        drain_next = drain_reg;
        count_next = count_reg;
        if (in_xfer)
        begin
            // a full store counts as the end of the block
            if (item.last || (count_reg == CNT_W'(BLOCK_LEN - 1)))
            begin
                drain_next = 1'b1;
                count_next = '0;
            end
            else
                count_next = count_reg + 1'b1;
        end
        if (out_xfer && result.last_res)
            drain_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            drain_reg <= drain_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/bms_checker.sv -----
// Port-level checks for the block merge sorter, bound to the top level.
// Depends on block_merge_sorter_core and its channel interfaces.
`default_nettype none

module bms_checker
    import bms_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic item_valid,
    input wire logic item_ready,
    input wire logic item_last,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire val_t res_value,
    input wire logic res_last
);

    // filling and draining never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_ready && res_valid))
        else $error("input ready while results pending");

    // a block end starts the drain in the next cycle
    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item_last) |=> res_valid)
        else $error("no result after last item");

    // the final result closes the block
    a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res_last) |=> (!res_valid && item_ready))
        else $error("results continue after last_res");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_value) && $stable(res_last)))
        else $error("stalled result changed");

endmodule

bind block_merge_sorter_core bms_checker u_bms_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_last  (item.last),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_value  (result.value_res),
    .res_last   (result.last_res)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for block_merge_sorter_core: random blocks of signed values in, sorted blocks out.
// Depends on bms_pkg, bms_in_if, bms_out_if and the core; predicts each block in a queue model.
`timescale 1ns / 1ps

module testbench;
    import bms_pkg::*;

    typedef struct {
        val_t value;
        logic last;
    } word_t;

    localparam val_t VAL_MIN = val_t'(32'h8000_0000);
    localparam val_t VAL_MAX = val_t'(32'h7FFF_FFFF);

    logic clk = 1'b0;
    logic rst_n;

    bms_in_if  item_ch ();
    bms_out_if result_ch ();

    block_merge_sorter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    word_t pending_items[$];
    val_t  held_values[$];      // current block, kept in ascending order
    word_t sorted_results[$];   // results still owed by the core

    val_t corner_vals[6] = '{VAL_MIN, VAL_MAX, 0, -1, VAL_MIN + 1, VAL_MAX - 1};

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   items_queued  = 0;
    int   items_taken   = 0;
    int   mismatch_count = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    bit   in_quiet  = 1'b0;
    bit   out_quiet = 1'b0;
    int   stall_left = 0;
    bit   stall_done = 1'b0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] %s", $time, what);
    endtask

    task automatic offer_word(input val_t v, input logic l);
        word_t w;
        w.value = v;
        w.last  = l;
        pending_items = {pending_items, w};
        items_queued++;
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // sender: one item offered at a time, random gap after each transfer
    always @(negedge clk)
    begin : drive_items
        logic  offer;
        val_t  nv;
        logic  nl;
        word_t nxt;
        if (rst_n === 1'b1)
        begin
            offer = item_ch.valid && !in_fire;
            nv = item_ch.value;
            nl = item_ch.last;
            if (!offer)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    offer = 1'b1;
                    nv = nxt.value;
                    nl = nxt.last;
                    tx_gap = in_quiet ? 0 : $urandom_range(0, 5);
                    if ($urandom_range(0, 31) == 0)
                        in_quiet = !in_quiet;
                end
            end
            item_ch.valid <= offer;
            item_ch.value <= nv;
            item_ch.last  <= nl;
        end
    end

    // receiver: random gap after each transfer, plus the long hold-off below
    always @(negedge clk)
    begin : drive_ready
        if (rst_n === 1'b1)
        begin
            if (out_fire)
            begin
                rx_gap = out_quiet ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 31) == 0)
                    out_quiet = !out_quiet;
            end
            else if (rx_gap > 0)
                rx_gap--;
            result_ch.ready <= (rx_gap == 0) && (stall_left == 0);
        end
    end

    // long output stall once the run is under way, so the core fills and blocks input
    always @(negedge clk)
    begin : hold_off
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!stall_done && items_taken >= 150)
        begin
            stall_left <= 400;
            stall_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : predict_and_check
        int    pos;
        word_t w;
        word_t want;
        if (rst_n !== 1'b1)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            in_fire  <= item_ch.valid && item_ch.ready;
            out_fire <= result_ch.valid && result_ch.ready;
            if (item_ch.valid && item_ch.ready)
            begin
                items_taken <= items_taken + 1;
                pos = 0;
                while (pos < held_values.size() && held_values[pos] <= item_ch.value)
                    pos++;
                held_values.insert(pos, item_ch.value);
                // a full store closes the block as if marked last
                if (item_ch.last || held_values.size() == BLOCK_LEN)
                begin
                    foreach (held_values[k])
                    begin
                        w.value = held_values[k];
                        w.last  = (k == held_values.size() - 1);
                        sorted_results = {sorted_results, w};
                    end
                    held_values.delete();
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (sorted_results.size() == 0)
                    report_mismatch($sformatf("unexpected result value_res=%0d last_res=%b",
                                              result_ch.value_res, result_ch.last_res));
                else
                begin
                    want = sorted_results.pop_front();
                    if (result_ch.value_res !== want.value)
                        report_mismatch($sformatf("value_res %0d, expected %0d",
                                                  result_ch.value_res, want.value));
                    if (result_ch.last_res !== want.last)
                        report_mismatch($sformatf("last_res %b, expected %b (value %0d)",
                                                  result_ch.last_res, want.last, want.value));
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("block_merge_sorter_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int   blocks;
        int   len;
        int   pick;
        int   flavor;
        int   f;
        logic mark_end;
        val_t v;

        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.value = '0;
        item_ch.last  = 1'b0;
        result_ch.ready = 1'b0;

        // directed: single-element blocks, extremes side by side, ties, reversed input
        offer_word(VAL_MAX, 1'b1);
        offer_word(VAL_MIN, 1'b1);
        offer_word(0, 1'b0);
        offer_word(-1, 1'b0);
        offer_word(VAL_MAX, 1'b0);
        offer_word(VAL_MIN, 1'b0);
        offer_word(1, 1'b1);
        offer_word(7, 1'b0);
        offer_word(-3, 1'b0);
        offer_word(7, 1'b0);
        offer_word(7, 1'b0);
        offer_word(-3, 1'b1);
        offer_word(100, 1'b0);
        offer_word(50, 1'b0);
        offer_word(0, 1'b0);
        offer_word(-50, 1'b0);
        offer_word(-100, 1'b1);
        offer_word(-2, 1'b0);
        offer_word(-1, 1'b0);
        offer_word(0, 1'b0);
        offer_word(1, 1'b1);

        // random blocks; the first two fill the store, without and with a last mark
        blocks = 0;
        while (items_queued < 520)
        begin
            pick = $urandom_range(0, 24);
            mark_end = 1'b1;
            if (blocks == 0 || pick == 0)
            begin
                len = BLOCK_LEN;
                mark_end = 1'b0;
            end
            else if (blocks == 1 || pick == 1)
                len = BLOCK_LEN;
            else if (pick < 5)
                len = $urandom_range(17, BLOCK_LEN - 1);
            else
                len = $urandom_range(1, 16);
            flavor = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
            begin
                f = (flavor == 3) ? $urandom_range(0, 2) : flavor;
                case (f)
                    0:       v = val_t'($urandom);
                    1:       v = val_t'($urandom_range(0, 8)) - 4;
                    default: v = corner_vals[$urandom_range(0, 5)];
                endcase
                offer_word(v, mark_end && (i == len - 1));
            end
            blocks++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_ch.valid)
            @(posedge clk);
        while (sorted_results.size() != 0)
            @(posedge clk);
        repeat (4 * BLOCK_LEN) @(posedge clk);

        if (mismatch_count == 0)
            $display("block_merge_sorter_core: match");
        else
            $display("block_merge_sorter_core: mismatch");
        $finish;
    end

endmodule
